@@ hw/rtl/wbps_pkg.sv @@
// Shared types and constants for the wildcard byte pattern search block.
// Holds the configuration register map and the configuration struct.
// No dependencies.
`default_nettype none

package wbps_pkg;

    // Register map of the configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_PATTERN_LEN  = 3'd2,
        CFG_WILDCARD_EN  = 3'd3,
        CFG_WILDCARD     = 3'd4,
        CFG_START_OFFSET = 3'd5,
        CFG_OCCURRENCE   = 3'd6
    } cfg_index_t;

    // Pattern storage is fixed at sixteen bytes by the register map
    localparam int PATTERN_BYTES = 16;
    localparam int LEN_W         = 5;
    localparam int POS_W         = 32;
    localparam int COUNT_W       = 16;

    localparam logic [POS_W-1:0]   POS_SAT   = {POS_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [8*PATTERN_BYTES-1:0] pattern;
        logic [LEN_W-1:0]           pattern_length;
        logic                       wildcard_enable;
        logic [7:0]                 wildcard_byte;
        logic [POS_W-1:0]           start_offset;
        logic [COUNT_W-1:0]         occurrence_wanted;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/wbps_cfg.sv @@
// Configuration register file of the pattern search block.
// Depends on wbps_pkg for the register map and cfg_t.
`default_nettype none

module wbps_cfg
    import wbps_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern           <= '0;
            cfg_reg.pattern_length    <= LEN_W'(1);
            cfg_reg.wildcard_enable   <= 1'b0;
            cfg_reg.wildcard_byte     <= '0;
            cfg_reg.start_offset      <= '0;
            cfg_reg.occurrence_wanted <= COUNT_W'(1);
        end else if (wr_en) begin
            case (wr_index)
                CFG_PATTERN_LOW:  cfg_reg.pattern[63:0]     <= wr_data;
                CFG_PATTERN_HIGH: cfg_reg.pattern[127:64]   <= wr_data;
                CFG_PATTERN_LEN:  cfg_reg.pattern_length    <= wr_data[LEN_W-1:0];
                CFG_WILDCARD_EN:  cfg_reg.wildcard_enable   <= wr_data[0];
                CFG_WILDCARD:     cfg_reg.wildcard_byte     <= wr_data[7:0];
                CFG_START_OFFSET: cfg_reg.start_offset      <= wr_data[POS_W-1:0];
                CFG_OCCURRENCE:   cfg_reg.occurrence_wanted <= wr_data[COUNT_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/wbps_match.sv @@
// Byte window shift line and parallel masked window compare.
// Depends on wbps_pkg for the pattern width constants.
`default_nettype none

module wbps_match
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       shift_en,
    input  wire logic [7:0]                 data_byte,
    input  wire logic [8*PATTERN_BYTES-1:0] pattern,
    input  wire logic [LEN_W-1:0]           used_length,
    input  wire logic                       wildcard_enable,
    input  wire logic [7:0]                 wildcard_byte,
    output logic                            window_match
);

    logic [7:0] window_reg [PATTERN_MAX];
    logic [7:0] window_next [PATTERN_MAX];
    logic [7:0] window16 [PATTERN_BYTES];

    // Newest byte sits at entry 0
    assign window_next[0] = data_byte;
    for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_shift
        assign window_next[k] = window_reg[k-1];
    end

    // Only the sixteen newest entries can ever take part in a compare
    for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_view
        if (k < PATTERN_MAX) begin : g_tap
            assign window16[k] = window_next[k];
        end else begin : g_zero
            assign window16[k] = 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            window_reg <= window_next;
        end
    end

    // Pattern byte j lines up with the byte len-1-j places back
    always_comb begin
        logic [LEN_W-1:0] sel;
        logic [7:0]       p;
        logic [7:0]       d;
        window_match = 1'b1;
        for (int j = 0; j < PATTERN_BYTES; j++) begin
            sel = used_length - LEN_W'(j) - LEN_W'(1);
            p   = pattern[8*j +: 8];
            d   = window16[sel[3:0]];
            if (LEN_W'(j) < used_length) begin
                if (!(p == d || (wildcard_enable && p == wildcard_byte))) begin
                    window_match = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/wildcard_byte_pattern_search_top.sv @@
// Path: a taken byte passes the input register, then the result register.
// Throughput: one byte per cycle unless results stall; combinational compare and checks.
// Results: at most one per buffer on found, or one found=0 word at the buffer end.
// Reset: synchronous, active low; clears valids, position, count, done; resets config.
// The byte window holds no reset; bytes older than the current buffer are never compared.
// Configuration is taken in every cycle; write it only while the block is idle.
`default_nettype none

module wildcard_byte_pattern_search_top
    import wbps_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // byte input channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_data_byte,
    input  wire logic                   s_last_byte,
    // result channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_found,
    output logic [POS_W-1:0]            m_match_position
);

    // Lengths above the window depth saturate, as do lengths above sixteen
    localparam int LEN_CAP = (PATTERN_MAX < PATTERN_BYTES) ? PATTERN_MAX : PATTERN_BYTES;

    cfg_t cfg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // Per-buffer search state
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               done_reg;
    logic               done_next;

    // Result register
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [POS_W-1:0]   out_pos_reg;

    logic               advance;
    logic [LEN_W-1:0]   used_length;
    logic [POS_W-1:0]   len_minus_one;
    logic [POS_W-1:0]   start_pos;
    logic               window_match;
    logic               hit;
    logic [COUNT_W-1:0] count_inc;
    logic               found;
    logic               emit;

    // ---------------------------------------------------------------
    // Configuration: always ready, write straight into the register file
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    wbps_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // ---------------------------------------------------------------
    // Handshake: advance the input word into the compare when the result
    // register is empty or being emptied this cycle
    // ---------------------------------------------------------------
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // ---------------------------------------------------------------
    // Window compare
    // ---------------------------------------------------------------
    assign used_length = (cfg.pattern_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                                : cfg.pattern_length;

    wbps_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .aclk            (aclk),
        .shift_en        (advance),
        .data_byte       (in_data_reg),
        .pattern         (cfg.pattern),
        .used_length     (used_length),
        .wildcard_enable (cfg.wildcard_enable),
        .wildcard_byte   (cfg.wildcard_byte),
        .window_match    (window_match)
    );

    // ---------------------------------------------------------------
    // Position and occurrence checks. A match ending at this byte starts
    // len-1 bytes back; it needs a full window inside the buffer and a
    // start at or past the offset. The saturated last index never matches.
    // ---------------------------------------------------------------
    assign len_minus_one = POS_W'(used_length) - POS_W'(1);
    assign start_pos     = pos_reg - len_minus_one;

    assign hit = !done_reg
              && (used_length != '0)
              && (pos_reg != POS_SAT)
              && (pos_reg >= len_minus_one)
              && (start_pos >= cfg.start_offset)
              && window_match;

    // Hold the count at its ceiling rather than wrap
    assign count_inc = (count_reg != COUNT_SAT) ? count_reg + COUNT_W'(1) : count_reg;

    // An occurrence of zero behaves as one since the count is at least one here
    assign found = hit && (count_inc >= cfg.occurrence_wanted);

    // A found word on the last byte replaces the end-of-buffer word
    assign emit = found || (in_last_reg && !done_reg);

    always_comb begin
        if (in_last_reg) begin
            pos_next   = '0;
            count_next = '0;
            done_next  = 1'b0;
        end else begin
            pos_next   = (pos_reg != POS_SAT) ? pos_reg + POS_W'(1) : pos_reg;
            count_next = hit ? count_inc : count_reg;
            done_next  = done_reg || found;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register: load on an emitting advance, drop once taken
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_found_reg <= found;
            out_pos_reg   <= found ? start_pos : '0;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_found          = out_found_reg;
    assign m_match_position = out_pos_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_found_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && found && !in_last_reg) |=> done_reg)
        else $error("found match did not close the search");

    a_done_blocks_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !hit)
        else $error("match counted after the search closed");

    a_last_clears_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (pos_reg == '0 && count_reg == '0 && !done_reg))
        else $error("buffer end did not clear search state");

    a_not_found_zero_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_match_position == '0))
        else $error("not-found word carries a position");

    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("result register overwritten while held");

endmodule

`default_nettype wire
